// ----- rtl/vda_pkg.sv -----
// Shared constants, stage record type and arctangent table for the vector direction block.
package vda_pkg;

  localparam int IN_W        = 16;
  localparam int OUT_W       = 15;
  localparam int DIRECTIONS  = 128;
  localparam int FRAC_BITS   = 8;
  localparam int ITERATIONS  = 16;
  localparam int ATAN_STAGES = 24;
  localparam int STAGES      = (ITERATIONS < ATAN_STAGES) ? ITERATIONS : ATAN_STAGES;
  localparam int IN_SHIFT    = 20;
  localparam int VEC_W       = 40;
  localparam int ACC_W       = 32;
  localparam int FULL_TURN   = DIRECTIONS << FRAC_BITS;
  localparam logic [ACC_W-1:0] HALF_TURN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef struct packed {
    logic                    valid;
    logic                    zero;
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic [ACC_W-1:0]        acc;
  } vda_stage_t;

  // atan(2^-i) as a fraction of one turn, 2^32 per turn
  function automatic logic [ACC_W-1:0] atan_turn(input int idx);
    logic [ACC_W-1:0] v;
    case (idx)
      0:       v = 32'h2000_0000;
      1:       v = 32'h12E4_051E;
      2:       v = 32'h09FB_385B;
      3:       v = 32'h0511_11D4;
      4:       v = 32'h028B_0D43;
      5:       v = 32'h0145_D7E1;
      6:       v = 32'h00A2_F61E;
      7:       v = 32'h0051_7C55;
      8:       v = 32'h0028_BE53;
      9:       v = 32'h0014_5F2F;
      10:      v = 32'h000A_2F98;
      11:      v = 32'h0005_17CC;
      12:      v = 32'h0002_8BE6;
      13:      v = 32'h0001_45F3;
      14:      v = 32'd41722;
      15:      v = 32'd20861;
      16:      v = 32'd10430;
      17:      v = 32'd5215;
      18:      v = 32'd2608;
      19:      v = 32'd1304;
      20:      v = 32'd652;
      21:      v = 32'd326;
      22:      v = 32'd163;
      23:      v = 32'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/vda_prep.sv -----
// Input stage: scale the vector, fold the left half plane, flag the zero vector.
module vda_prep (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       req_valid,
  input  logic signed [15:0]         vec_x,
  input  logic signed [15:0]         vec_y,
  output vda_pkg::vda_stage_t        prep_stage
);
  import vda_pkg::*;

  vda_stage_t              prep_r;
  vda_stage_t              prep_nxt;
  logic signed [VEC_W-1:0] xs;
  logic signed [VEC_W-1:0] ys;

  always_comb begin
    xs = {{(VEC_W-IN_W-IN_SHIFT){vec_x[IN_W-1]}}, vec_x, {IN_SHIFT{1'b0}}};
    ys = {{(VEC_W-IN_W-IN_SHIFT){vec_y[IN_W-1]}}, vec_y, {IN_SHIFT{1'b0}}};
    prep_nxt.valid = req_valid;
    prep_nxt.zero  = (vec_x == '0) && (vec_y == '0);
    if (vec_x[IN_W-1]) begin
      // turn by half a turn
      prep_nxt.x   = -xs;
      prep_nxt.y   = -ys;
      prep_nxt.acc = HALF_TURN;
    end else begin
      prep_nxt.x   = xs;
      prep_nxt.y   = ys;
      prep_nxt.acc = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_r.valid <= 1'b0;
    end else begin
      prep_r <= prep_nxt;
    end
  end

  assign prep_stage = prep_r;

endmodule

// ----- rtl/vda_core.sv -----
// CORDIC vectoring pipeline: one registered micro-rotation per stage.
module vda_core (
  input  logic                clk,
  input  logic                rst_n,
  input  vda_pkg::vda_stage_t core_in,
  output vda_pkg::vda_stage_t core_out
);
  import vda_pkg::*;

  vda_stage_t stage_r [0:STAGES-1];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam int SH = i;
    vda_stage_t              cur;
    vda_stage_t              stage_nxt;
    logic signed [VEC_W-1:0] dx;
    logic signed [VEC_W-1:0] dy;

    if (i == 0) begin : g_first
      assign cur = core_in;
    end else begin : g_next
      assign cur = stage_r[i-1];
    end

    always_comb begin
      dx = cur.y >>> SH;
      dy = cur.x >>> SH;
      stage_nxt       = cur;
      if (!cur.y[VEC_W-1]) begin
        stage_nxt.x   = cur.x + dx;
        stage_nxt.y   = cur.y - dy;
        stage_nxt.acc = cur.acc + atan_turn(SH);
      end else begin
        stage_nxt.x   = cur.x - dx;
        stage_nxt.y   = cur.y + dy;
        stage_nxt.acc = cur.acc - atan_turn(SH);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stage_r[i].valid <= 1'b0;
      end else begin
        stage_r[i] <= stage_nxt;
      end
    end
  end

  assign core_out = stage_r[STAGES-1];

endmodule

// ----- rtl/vda_scale.sv -----
// Output stage: scale the binary angle to output units, round, wrap a full turn.
module vda_scale (
  input  logic                   clk,
  input  logic                   rst_n,
  input  vda_pkg::vda_stage_t    fin,
  output logic                   out_strobe,
  output logic [14:0]            out_angle
);
  import vda_pkg::*;

  logic [63:0]       prod;
  logic [31:0]       rounded;
  logic [OUT_W-1:0]  angle_nxt;
  logic              strobe_r;
  logic [OUT_W-1:0]  angle_r;

  always_comb begin
    prod    = 64'(fin.acc) * 64'(FULL_TURN) + 64'h0000_0000_8000_0000;
    rounded = prod[63:32];
    if (fin.zero || (rounded >= 32'(FULL_TURN))) begin
      angle_nxt = '0;
    end else begin
      angle_nxt = rounded[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    angle_r <= angle_nxt;
    if (!rst_n) strobe_r <= 1'b0;
    else        strobe_r <= fin.valid;
  end

  assign out_strobe = strobe_r;
  assign out_angle  = angle_r;

endmodule

// ----- rtl/vector_direction_angle.sv -----
// Top level of the vector direction block: CORDIC atan2 in a fully pipelined datapath.
//
//   channel  ports                          handshake
//   -------  -----------------------------  ------------------------------------
//   input    in_vec_x[15:0], in_vec_y[15:0] request taken when start && !busy
//   result   out_angle[14:0]                out_strobe high for one cycle
//
// One request enters every cycle; busy stays low, so no request is ever held off.
// The pipeline has one input stage, 16 CORDIC stages (one per iteration,
// one 40-bit add/subtract pair each) and one scaling stage with the constant multiply.
// Reset (synchronous, active low) clears the valid bit of every stage; data needs none.
// The receiver cannot stall, so results leave the last stage as they arrive.
module vector_direction_angle (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic signed [15:0]  in_vec_x,
  input  logic signed [15:0]  in_vec_y,
  output logic                out_strobe,
  output logic [14:0]         out_angle
);
  import vda_pkg::*;

  vda_stage_t prep_stage;
  vda_stage_t fin_stage;
  logic       req_valid;

  // The pipeline never backs up: take a request in every cycle.
  assign busy      = 1'b0;
  assign req_valid = start && !busy;

  // Scale to 2^20, fold vectors in the left half plane by half a turn.
  vda_prep u_prep (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req_valid),
    .vec_x      (in_vec_x),
    .vec_y      (in_vec_y),
    .prep_stage (prep_stage)
  );

  // Drive y toward zero, accumulating the rotation angle.
  vda_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .core_in  (prep_stage),
    .core_out (fin_stage)
  );

  // Convert the binary angle to output units and register the result.
  vda_scale u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .fin        (fin_stage),
    .out_strobe (out_strobe),
    .out_angle  (out_angle)
  );

  // A result leaves in the cycle after its request reaches the last CORDIC stage.
  a_strobe_follows_stage: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe == ($past(rst_n) && $past(fin_stage.valid)))
    else $error("result strobe does not follow last stage valid");

  // The zero vector always reports angle zero.
  a_zero_vector: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && $past(rst_n) && $past(fin_stage.zero)) |-> (out_angle == '0))
    else $error("zero vector gave a nonzero angle");

  // No request may be dropped while the pipeline reports not busy.
  a_never_busy_loss: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> prep_stage.valid)
    else $error("accepted request did not enter the pipeline");

endmodule
